FILE: design/multi_line_switch_debouncer_unit_macros.svh
// Assertion macros shared by the switch debouncer RTL.
`ifndef MULTI_LINE_SWITCH_DEBOUNCER_UNIT_MACROS_SVH
`define MULTI_LINE_SWITCH_DEBOUNCER_UNIT_MACROS_SVH

// Same-cycle implication, checked on rising clk outside reset.
`define MLSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on rising clk outside reset.
`define MLSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/mlsd_pkg.sv
// Shared constants and types of the switch debouncer.
package mlsd_pkg;

  localparam int NUM_LINES  = 10;
  localparam int TIME_W     = 32;
  localparam int LINE_IDX_W = $clog2(NUM_LINES);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENT_MASK = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [TIME_W-1:0]    DEBOUNCE_RST = TIME_W'(10);
  localparam logic [NUM_LINES-1:0] PRESENT_RST  = {NUM_LINES{1'b1}};

  // Depth of the queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One classified poll: lines that newly became active and the poll time.
  typedef struct packed {
    logic [NUM_LINES-1:0] act;
    logic [TIME_W-1:0]    stamp;
  } mlsd_item_t;

endpackage

FILE: design/mlsd_front.sv
// Front part: configuration registers, per-line debounce state and poll classification.
module mlsd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [mlsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mlsd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mlsd_pkg::TIME_W-1:0]    in_poll_time_ms,
  input  logic [mlsd_pkg::NUM_LINES-1:0] in_line_levels,
  output logic                          push_valid,
  input  logic                          push_ready,
  output mlsd_pkg::mlsd_item_t          push_item
);
  import mlsd_pkg::*;

  logic [TIME_W-1:0]    debounce_r;
  logic [NUM_LINES-1:0] present_r;
  logic [NUM_LINES-1:0] level_r;
  logic [TIME_W-1:0]    change_time_r [NUM_LINES];
  logic [NUM_LINES-1:0] change;
  logic [NUM_LINES-1:0] act;
  logic                 accept;

  // Per-line change test: line present, level differs and lockout time has elapsed.
  always_comb begin
    for (int i = 0; i < NUM_LINES; i++) begin
      change[i] = present_r[i] && (in_line_levels[i] != level_r[i]) &&
                  ((in_poll_time_ms - change_time_r[i]) >= debounce_r);
    end
  end

  assign act        = change & in_line_levels;
  assign in_ready   = push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = in_valid && (act != '0);
  assign push_item  = '{act: act, stamp: in_poll_time_ms};

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      present_r  <= PRESENT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEBOUNCE_MS:  debounce_r <= cfg_data[TIME_W-1:0];
        REG_PRESENT_MASK: present_r  <= cfg_data[NUM_LINES-1:0];
        default: ;
      endcase
    end
  end

  // Store the new level and time of every line that changed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      for (int i = 0; i < NUM_LINES; i++) begin
        change_time_r[i] <= '0;
      end
    end else if (accept) begin
      for (int i = 0; i < NUM_LINES; i++) begin
        if (change[i]) begin
          level_r[i]       <= in_line_levels[i];
          change_time_r[i] <= in_poll_time_ms;
        end
      end
    end
  end

endmodule

FILE: design/mlsd_queue.sv
// Short queue of classified polls between the front and back parts.
module mlsd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  mlsd_pkg::mlsd_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output mlsd_pkg::mlsd_item_t pop_item
);
  import mlsd_pkg::*;

  mlsd_item_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              push;
  logic              pop;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: design/mlsd_back.sv
// Back part: emits one event word per cycle while out_ready is high, lowest active line first.
module mlsd_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  output logic                            q_ready,
  input  mlsd_pkg::mlsd_item_t            q_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mlsd_pkg::LINE_IDX_W-1:0] out_event_line,
  output logic [mlsd_pkg::TIME_W-1:0]     out_event_time_ms,
  output logic                            out_last_event
);
  import mlsd_pkg::*;

  logic [NUM_LINES-1:0] act_r;
  logic [NUM_LINES-1:0] act_nxt;
  logic [TIME_W-1:0]    stamp_r;
  logic [NUM_LINES-1:0] low;
  logic [LINE_IDX_W-1:0] idx;
  logic                 busy;
  logic                 last;
  logic                 take;

  // Isolate the lowest pending line and encode its index.
  assign low = act_r & (~act_r + 1'b1);
  always_comb begin
    idx = '0;
    for (int i = 0; i < NUM_LINES; i++) begin
      if (low[i]) begin
        idx = idx | LINE_IDX_W'(i);
      end
    end
  end

  assign busy = (act_r != '0);
  assign last = ((act_r & ~low) == '0);
  assign take = !busy || (out_ready && last);
  assign q_ready = take;

  assign out_valid         = busy;
  assign out_event_line    = idx;
  assign out_event_time_ms = stamp_r;
  assign out_last_event    = last;

  // Next pending set: reload from the queue or drop the line just sent.
  always_comb begin
    act_nxt = act_r;
    if (take) begin
      act_nxt = q_valid ? q_item.act : '0;
    end else if (out_ready) begin
      act_nxt = act_r & ~low;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= '0;
    end else begin
      act_r <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && q_valid) begin
      stamp_r <= q_item.stamp;
    end
  end

endmodule

FILE: design/multi_line_switch_debouncer_unit.sv
// Top level of the multi-line switch debouncer.
//
//   channel | direction | words                 | handshake
//   in_     | input     | one poll              | in_valid / in_ready
//   out_    | output    | one activation event  | out_valid / out_ready
//   cfg_    | input     | one register write    | cfg_valid / cfg_ready
//
// A poll is classified and its line state updated in the cycle it is accepted.
// A poll that activates k lines gives k event words (at most ten), one per cycle while
// out_ready is high; a poll with no activation never enters the queue. When idle,
// an accepted poll passes the queue entry and the back part's pending register before
// its first word leaves. in_ready drops only while the two-entry queue is full; reset
// is synchronous, and cfg_ready is always high.
`include "multi_line_switch_debouncer_unit_macros.svh"

module multi_line_switch_debouncer_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mlsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mlsd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mlsd_pkg::TIME_W-1:0]     in_poll_time_ms,
  input  logic [mlsd_pkg::NUM_LINES-1:0]  in_line_levels,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mlsd_pkg::LINE_IDX_W-1:0] out_event_line,
  output logic [mlsd_pkg::TIME_W-1:0]     out_event_time_ms,
  output logic                            out_last_event
);
  import mlsd_pkg::*;

  logic       push_valid;
  logic       push_ready;
  mlsd_item_t push_item;
  logic       q_valid;
  logic       q_ready;
  mlsd_item_t q_item;

  assign cfg_ready = 1'b1;

  // Front: classify polls and keep per-line state.
  mlsd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_poll_time_ms (in_poll_time_ms),
    .in_line_levels  (in_line_levels),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_item       (push_item)
  );

  // Queue between the two sides.
  mlsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // Back: serialize events.
  mlsd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_ready           (q_ready),
    .q_item            (q_item),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_line    (out_event_line),
    .out_event_time_ms (out_event_time_ms),
    .out_last_event    (out_last_event)
  );

  // Design checks.
  `MLSD_ASSERT_NOW(a_line_range, out_valid, out_event_line < LINE_IDX_W'(NUM_LINES), "event line out of range")
  `MLSD_ASSERT_NEXT(a_more_events, out_valid && out_ready && !out_last_event, out_valid, "event burst ended early")
  `MLSD_ASSERT_NEXT(a_drain, out_valid && out_ready && out_last_event && !q_valid, !out_valid, "event after last word")

endmodule
